@@ src/vkls_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// vkls_pkg: keyframe sampler package
// types, constants and state codes shared by the sampler modules
// ----------------------------------------------------------------------------
package vkls_pkg;

	localparam int MAX_KEYS   = 64;
	localparam int KEY_W      = $clog2(MAX_KEYS);
	localparam int CNT_W      = 7;
	localparam int COMPONENTS = 3;
	localparam int FRAC_W     = 16;
	localparam logic [16:0] BLEND_ONE = 17'h10000;

	localparam logic REQ_LOAD   = 1'b0;
	localparam logic REQ_SAMPLE = 1'b1;

	typedef struct packed {
		logic               req_type;
		logic [5:0]         key_index;
		logic [31:0]        time_point;
		logic signed [31:0] value_x;
		logic signed [31:0] value_y;
		logic signed [31:0] value_z;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] out_x;
		logic signed [31:0] out_y;
		logic signed [31:0] out_z;
		logic [16:0]        blend;
		logic [5:0]         segment;
	} res_item_t;

	typedef struct packed {
		logic [31:0]        key_time;
		logic signed [31:0] key_x;
		logic signed [31:0] key_y;
		logic signed [31:0] key_z;
	} key_entry_t;

	typedef struct packed {
		logic        go;
		logic [16:0] blend;
	} lane_ctl_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_DRAIN,
		ST_FETCH_A,
		ST_FETCH_B,
		ST_CAPB,
		ST_DIV,
		ST_LANE,
		ST_WAIT
	} state_t;

endpackage
`default_nettype wire

@@ src/vector_keyframe_lerp_sampler_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// vector_keyframe_lerp_sampler_core: keyframe table with linear sampling
// ----------------------------------------------------------------------------
// an item is taken when start is high and busy is low. a load item writes
// one table entry at the accepting edge and gives no result. a sample item
// scans the stored times one per cycle through the single table read port,
// reads the two keys of the chosen segment, divides for the blend factor with
// a restoring divider at one quotient bit a cycle, then three lanes form the
// x, y and z components in parallel, two stages each. the divider is skipped
// for a single key, a segment of no length or a time at or past the later
// key, and a single key also skips the scan; the next item is taken in the
// cycle after the result at the earliest, loads are taken every cycle while
// no sample is running
// the result shows for one cycle with done high; the receiver cannot stall
// cfg writes key_count and is always ready; the table is not cleared by
// reset and key_count resets to one
// ----------------------------------------------------------------------------
module vector_keyframe_lerp_sampler_core (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	output logic                             busy,
	input  wire vkls_pkg::in_item_t          in,
	output logic                             done,
	output vkls_pkg::res_item_t              result,
	input  wire logic                        cfg_valid,
	output logic                             cfg_ready,
	input  wire logic [vkls_pkg::CNT_W-1:0]  cfg_data
);

	localparam int KW = vkls_pkg::KEY_W;
	localparam int NC = vkls_pkg::COMPONENTS;

	vkls_pkg::state_t state_q, state_d;

	logic [vkls_pkg::CNT_W-1:0] count_q;
	logic [vkls_pkg::CNT_W-1:0] n_eff;
	logic [KW-1:0]              last_k;
	logic [KW-1:0]              k_q, cmp_k_q, seg_q, rd_addr;
	logic                       cmp_v_q;
	logic [31:0]                t_q, tk_q, rem_q, den_q;
	logic [15:0]                quo_q;
	logic [3:0]                 cnt_q;
	logic                       single_q;
	logic [16:0]                blend_q;
	logic signed [31:0]         a_q [NC];
	logic signed [31:0]         b_q [NC];
	logic [32:0]                rem2;
	logic [31:0]                num;
	logic                       accept;
	vkls_pkg::key_entry_t       wr_entry, rd_entry;
	vkls_pkg::lane_ctl_t        lane_ctl;
	logic                       lane_valid [NC];
	logic signed [31:0]         lane_res [NC];

	assign accept    = start && !busy;
	assign busy      = (state_q != vkls_pkg::ST_IDLE);
	assign cfg_ready = 1'b1;

	always_comb begin
		if (count_q == '0) begin
			n_eff = vkls_pkg::CNT_W'(1);
		end else if (count_q > vkls_pkg::CNT_W'(vkls_pkg::MAX_KEYS)) begin
			n_eff = vkls_pkg::CNT_W'(vkls_pkg::MAX_KEYS);
		end else begin
			n_eff = count_q;
		end
	end
	assign last_k = KW'(n_eff - vkls_pkg::CNT_W'(2));

	assign wr_entry = '{key_time: in.time_point, key_x: in.value_x,
		key_y: in.value_y, key_z: in.value_z};

	always_comb begin
		unique case (state_q)
			vkls_pkg::ST_SEARCH:  rd_addr = k_q;
			vkls_pkg::ST_FETCH_A: rd_addr = seg_q;
			default:              rd_addr = seg_q + KW'(1);
		endcase
	end

	vkls_store u_store (
		.clk     (clk),
		.wr_en   (accept && in.req_type == vkls_pkg::REQ_LOAD),
		.wr_addr (in.key_index),
		.wr_data (wr_entry),
		.rd_addr (rd_addr),
		.rd_data (rd_entry)
	);

	assign num  = (t_q > tk_q) ? t_q - tk_q : 32'd0;
	assign rem2 = {rem_q, 1'b0};

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			vkls_pkg::ST_IDLE: begin
				if (accept && in.req_type == vkls_pkg::REQ_SAMPLE) begin
					state_d = (n_eff < vkls_pkg::CNT_W'(2)) ? vkls_pkg::ST_FETCH_A
						: vkls_pkg::ST_SEARCH;
				end
			end
			vkls_pkg::ST_SEARCH:  if (k_q == last_k) state_d = vkls_pkg::ST_DRAIN;
			vkls_pkg::ST_DRAIN:   state_d = vkls_pkg::ST_FETCH_A;
			vkls_pkg::ST_FETCH_A: state_d = vkls_pkg::ST_FETCH_B;
			vkls_pkg::ST_FETCH_B: state_d = vkls_pkg::ST_CAPB;
			vkls_pkg::ST_CAPB: begin
				if (single_q || rd_entry.key_time <= tk_q || num >= rd_entry.key_time - tk_q) begin
					state_d = vkls_pkg::ST_LANE;
				end else begin
					state_d = vkls_pkg::ST_DIV;
				end
			end
			vkls_pkg::ST_DIV:     if (cnt_q == 4'd15) state_d = vkls_pkg::ST_LANE;
			vkls_pkg::ST_LANE:    state_d = vkls_pkg::ST_WAIT;
			vkls_pkg::ST_WAIT:    if (lane_valid[0]) state_d = vkls_pkg::ST_IDLE;
			default:              state_d = vkls_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= vkls_pkg::ST_IDLE;
			count_q <= vkls_pkg::CNT_W'(1);
			cmp_v_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				count_q <= cfg_data;
			end
			cmp_v_q <= (state_q == vkls_pkg::ST_SEARCH);
		end
	end

	always_ff @(posedge clk) begin
		if (cmp_v_q && rd_entry.key_time <= t_q) begin
			seg_q <= cmp_k_q;
		end
		cmp_k_q <= k_q;
		unique case (state_q)
			vkls_pkg::ST_IDLE: begin
				t_q      <= in.time_point;
				k_q      <= '0;
				seg_q    <= '0;
				single_q <= (n_eff < vkls_pkg::CNT_W'(2));
			end
			vkls_pkg::ST_SEARCH: k_q <= k_q + KW'(1);
			vkls_pkg::ST_FETCH_B: begin
				tk_q   <= rd_entry.key_time;
				a_q[0] <= rd_entry.key_x;
				a_q[1] <= rd_entry.key_y;
				a_q[2] <= rd_entry.key_z;
			end
			vkls_pkg::ST_CAPB: begin
				if (single_q) begin
					b_q[0] <= a_q[0];
					b_q[1] <= a_q[1];
					b_q[2] <= a_q[2];
				end else begin
					b_q[0] <= rd_entry.key_x;
					b_q[1] <= rd_entry.key_y;
					b_q[2] <= rd_entry.key_z;
				end
				rem_q  <= num;
				den_q  <= rd_entry.key_time - tk_q;
				cnt_q  <= '0;
				if (single_q) begin
					blend_q <= '0;
				end else if (rd_entry.key_time <= tk_q) begin
					blend_q <= (t_q >= tk_q) ? vkls_pkg::BLEND_ONE : 17'd0;
				end else begin
					blend_q <= vkls_pkg::BLEND_ONE;
				end
			end
			vkls_pkg::ST_DIV: begin
				cnt_q <= cnt_q + 4'd1;
				if (rem2 >= {1'b0, den_q}) begin
					rem_q <= 32'(rem2 - {1'b0, den_q});
					quo_q <= {quo_q[14:0], 1'b1};
				end else begin
					rem_q <= rem2[31:0];
					quo_q <= {quo_q[14:0], 1'b0};
				end
				if (cnt_q == 4'd15) begin
					blend_q <= {1'b0, quo_q[14:0],
						(rem2 >= {1'b0, den_q})};
				end
			end
			default: ;
		endcase
	end

	assign lane_ctl = '{go: (state_q == vkls_pkg::ST_LANE), blend: blend_q};

	for (genvar c = 0; c < NC; c++) begin : g_lane
		vkls_lane u_lane (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (lane_ctl),
			.start_val (a_q[c]),
			.end_val   (b_q[c]),
			.valid     (lane_valid[c]),
			.result    (lane_res[c])
		);
	end

	assign done = lane_valid[0] && (state_q == vkls_pkg::ST_WAIT);
	assign result = '{out_x: lane_res[0], out_y: lane_res[1], out_z: lane_res[2],
		blend: blend_q, segment: seg_q};

	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n) done |-> busy)
		else $error("result strobe outside a sample");
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n) done |=> !busy)
		else $error("block stays busy after result");
	a_blend_rng: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> result.blend <= vkls_pkg::BLEND_ONE)
		else $error("blend above one");
	a_lanes_sync: assert property (@(posedge clk) disable iff (!arst_n)
		lane_valid[0] |-> lane_valid[NC-1])
		else $error("lanes out of step");

endmodule
`default_nettype wire

@@ src/vkls_store.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// vkls_store: keyframe table
// one write port for loads, one registered read port
// ----------------------------------------------------------------------------
module vkls_store (
	input  wire logic                       clk,
	input  wire logic                       wr_en,
	input  wire logic [vkls_pkg::KEY_W-1:0] wr_addr,
	input  wire vkls_pkg::key_entry_t       wr_data,
	input  wire logic [vkls_pkg::KEY_W-1:0] rd_addr,
	output vkls_pkg::key_entry_t            rd_data
);

	vkls_pkg::key_entry_t mem [vkls_pkg::MAX_KEYS];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule
`default_nettype wire

@@ src/vkls_lane.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// vkls_lane: one component lane
// start + floor((end - start) * blend / 2^16) over two stages
// ----------------------------------------------------------------------------
module vkls_lane (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire vkls_pkg::lane_ctl_t ctl,
	input  wire logic signed [31:0] start_val,
	input  wire logic signed [31:0] end_val,
	output logic                    valid,
	output logic signed [31:0]      result
);

	logic signed [32:0] diff;
	logic signed [50:0] prod_s1;
	logic signed [31:0] a_s1;
	logic               v_s1;
	logic               v_s2;
	logic signed [31:0] res_s2;

	assign diff = 33'(signed'({end_val[31], end_val})) - 33'(signed'({start_val[31], start_val}));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= ctl.go;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= 51'(diff) * 51'(signed'({1'b0, ctl.blend}));
		a_s1    <= start_val;
		res_s2  <= a_s1 + prod_s1[47:16];
	end

	assign valid  = v_s2;
	assign result = res_s2;

endmodule
`default_nettype wire

@@ sim/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench: keyframe lerp sampler
// runs directed cases, fills the keyframe table, then sends load and sample
// items under several key counts and sender idling patterns; every sample
// result is predicted from a local table copy and compared field by field
// ----------------------------------------------------------------------------
module testbench;
	import vkls_pkg::*;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int SETTLE_CYCLES  = 100;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 start = 1'b0;
	logic                 busy;
	in_item_t             in_item = '0;
	logic                 done;
	res_item_t            result;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CNT_W-1:0]     cfg_data = '0;

	logic [31:0]          key_time [MAX_KEYS];
	logic signed [31:0]   key_val  [MAX_KEYS][3];
	int unsigned          key_count_now = 1;
	res_item_t            pending_samples [$];
	int                   fails = 0;
	int                   idle_pct = 0;
	int                   idle_cycles = 0;
	logic [31:0]          time_step = 32'h10000;

	vector_keyframe_lerp_sampler_core uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .in(in_item),
		.done(done), .result(result), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	always #1 clk = ~clk;

	function automatic res_item_t sample_at(logic [31:0] t);
		res_item_t        r;
		int unsigned      n;
		int unsigned      seg;
		logic [31:0]      tk;
		logic [31:0]      tn;
		logic [31:0]      num;
		logic [63:0]      q;
		logic [16:0]      f;
		longint           a;
		longint           b;
		longint           prod;
		logic [31:0]      comp [3];
		n = key_count_now;
		if (n == 0) n = 1;
		if (n > MAX_KEYS) n = MAX_KEYS;
		seg = 0;
		f = '0;
		if (n >= 2) begin
			for (int k = 0; k + 1 < n; k++)
				if (key_time[k] <= t) seg = k;
			tk = key_time[seg];
			tn = key_time[seg + 1];
			num = (t > tk) ? t - tk : 32'd0;
			if (tn <= tk) begin
				f = (t >= tk) ? BLEND_ONE : 17'd0;
			end else begin
				q = ({32'd0, num} << 16) / {32'd0, tn - tk};
				f = (q > 64'd65536) ? BLEND_ONE : q[16:0];
			end
		end
		for (int c = 0; c < 3; c++) begin
			a = key_val[seg][c];
			if (n >= 2) begin
				b = key_val[seg + 1][c];
				prod = (b - a) * longint'({47'd0, f});
				a = a + (prod >>> 16);
			end
			comp[c] = a[31:0];
		end
		r.out_x = comp[0];
		r.out_y = comp[1];
		r.out_z = comp[2];
		r.blend = f;
		r.segment = seg[5:0];
		return r;
	endfunction

	function automatic logic [31:0] pick_value();
		int unsigned sel;
		sel = $urandom_range(9);
		if (sel == 0) return 32'h8000_0000;
		if (sel == 1) return 32'h7fff_ffff;
		return $urandom;
	endfunction

	function automatic in_item_t load_item(int idx, logic [31:0] t);
		in_item_t it;
		it.req_type = REQ_LOAD;
		it.key_index = idx[5:0];
		it.time_point = t;
		it.value_x = pick_value();
		it.value_y = pick_value();
		it.value_z = pick_value();
		return it;
	endfunction

	function automatic in_item_t sample_item(logic [31:0] t);
		in_item_t it;
		it.req_type = REQ_SAMPLE;
		it.key_index = 6'($urandom);
		it.time_point = t;
		it.value_x = $urandom;
		it.value_y = $urandom;
		it.value_z = $urandom;
		return it;
	endfunction

	task automatic send_item(in_item_t it);
		start <= 1'b1;
		in_item <= it;
		do @(posedge clk); while (busy);
		if (it.req_type == REQ_LOAD) begin
			key_time[it.key_index] = it.time_point;
			key_val[it.key_index][0] = it.value_x;
			key_val[it.key_index][1] = it.value_y;
			key_val[it.key_index][2] = it.value_z;
		end else begin
			pending_samples.push_back(sample_at(it.time_point));
		end
		if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	task automatic drain();
		start <= 1'b0;
		while (pending_samples.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_key_count(int unsigned cnt);
		drain();
		cfg_valid <= 1'b1;
		cfg_data <= cnt[CNT_W-1:0];
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		key_count_now = cnt & 32'h7f;
	endtask

	// extremes of values, degenerate segment, times around and outside keys
	task automatic test_directed();
		in_item_t it;
		set_key_count(4);
		it = load_item(0, 32'h0001_0000);
		it.value_x = 32'h8000_0000; it.value_y = 32'h7fff_ffff; it.value_z = 32'd0;
		send_item(it);
		it = load_item(1, 32'h0003_0000);
		it.value_x = 32'h7fff_ffff; it.value_y = 32'h8000_0000; it.value_z = -32'sd1;
		send_item(it);
		send_item(load_item(2, 32'h0003_0000));
		send_item(load_item(3, 32'hffff_ffff));
		send_item(sample_item(32'd0));
		send_item(sample_item(32'h0001_0000));
		send_item(sample_item(32'h0002_0000));
		send_item(sample_item(32'h0002_ffff));
		send_item(sample_item(32'h0003_0000));
		send_item(sample_item(32'h0004_0000));
		send_item(sample_item(32'hffff_ffff));
		set_key_count(1);
		send_item(sample_item(32'h0002_0000));
		set_key_count(0);
		send_item(sample_item(32'hffff_ffff));
	endtask

	task automatic test_fill_table();
		set_key_count(2);
		for (int i = 0; i < MAX_KEYS; i++)
			send_item(load_item(i, i * time_step + $urandom_range(0, time_step - 1)));
	endtask

	task automatic random_phase(int unsigned cnt, int pct, int items);
		int unsigned idx;
		set_key_count(cnt);
		idle_pct = pct;
		time_step = 32'd1 << $urandom_range(8, 24);
		for (int i = 0; i < items; i++) begin
			if ($urandom_range(99) < 35) begin
				idx = $urandom_range(MAX_KEYS - 1);
				if ($urandom_range(99) < 75)
					send_item(load_item(idx, idx * time_step +
						$urandom_range(0, time_step - 1)));
				else
					send_item(load_item(idx, $urandom));
			end else if ($urandom_range(99) < 80) begin
				send_item(sample_item($urandom_range(0, 65 * time_step)));
			end else begin
				send_item(sample_item($urandom));
			end
			if ($urandom_range(99) == 0) drain();
		end
		idle_pct = 0;
	endtask

	task automatic test_random();
		random_phase(MAX_KEYS, 0, 250);
		random_phase(2, 51, 250);
		random_phase($urandom_range(3, 63), 16, 250);
		random_phase(127, 0, 250);
		random_phase($urandom_range(1, 127), 51, 250);
	endtask

	always @(posedge clk) begin
		res_item_t want;
		if (arst_n && done) begin
			if (pending_samples.size() == 0) begin
				$error("result with no sample waiting");
				fails++;
			end else begin
				want = pending_samples.pop_front();
				if (result.out_x !== want.out_x) begin
					$error("out_x expected %0d got %0d", want.out_x, result.out_x);
					fails++;
				end
				if (result.out_y !== want.out_y) begin
					$error("out_y expected %0d got %0d", want.out_y, result.out_y);
					fails++;
				end
				if (result.out_z !== want.out_z) begin
					$error("out_z expected %0d got %0d", want.out_z, result.out_z);
					fails++;
				end
				if (result.blend !== want.blend) begin
					$error("blend expected %0d got %0d", want.blend, result.blend);
					fails++;
				end
				if (result.segment !== want.segment) begin
					$error("segment expected %0d got %0d", want.segment, result.segment);
					fails++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_fill_table();
		test_random();
		drain();
		if (fails == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

@@ vector_keyframe_lerp_sampler_core.f @@
src/vkls_pkg.sv
src/vkls_store.sv
src/vkls_lane.sv
src/vector_keyframe_lerp_sampler_core.sv
sim/testbench.sv
